@@ design/tick_sleep_queue_core_assert.svh @@
// ----------------------------------------------------------------------------
// tick_sleep_queue_core assertion macros
// Concurrent assertion helpers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef TICK_SLEEP_QUEUE_CORE_ASSERT_SVH
`define TICK_SLEEP_QUEUE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ design/tsq_pkg.sv @@
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types and constants of the tick sleep queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int unsigned TickW   = 32;
    localparam int unsigned ThreadW = 8;
    localparam int unsigned DelayW  = 16;

    localparam logic ActTick  = 1'b0;
    localparam logic ActSleep = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        logic [TickW-1:0]   wake;
        logic [ThreadW-1:0] thread;
    } t_entry;

    typedef struct packed {
        logic               hit;
        logic [ThreadW-1:0] thread;
    } t_chain;

endpackage

@@ design/tsq_cell.sv @@
// ----------------------------------------------------------------------------
// tsq_cell
// One queue slot: holds an entry, checks it for wake-up, shifts on removal.
// ----------------------------------------------------------------------------
module tsq_cell
    import tsq_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_live,
    input  logic             i_load,
    input  t_entry           i_new,
    input  logic             i_shift_en,
    input  t_entry           i_next,
    input  logic [TickW-1:0] i_tick,
    input  t_chain           i_chain,
    output t_chain           o_chain,
    output t_entry           o_entry
);

    t_entry r_entry;
    logic   due;

    assign due            = i_live && (i_tick >= r_entry.wake);
    assign o_chain.hit    = i_chain.hit || due;
    assign o_chain.thread = (due && !i_chain.hit) ? r_entry.thread : i_chain.thread;
    assign o_entry        = r_entry;

    // load on append, pull from neighbor at and after the removed slot
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_new;
        end else if (i_shift_en && o_chain.hit) begin
            r_entry <= i_next;
        end
    end

endmodule

@@ design/tick_sleep_queue_core.sv @@
// ----------------------------------------------------------------------------
// tick_sleep_queue_core
// Timer-tick driven sleep queue built as a row of slot cells.
// ----------------------------------------------------------------------------
// A sleep beat appends (thread, tick count + delay) in arrival order, or flags
// queue_full when all QUEUE_DEPTH slots are taken; its result is registered.
// A tick beat is taken in ST_IDLE, which advances the saturating tick count;
// then ST_SCAN walks the row of slot cells, where the first due entry ripples
// through the cell chain, is reported and the later slots close the gap.
// One beat is in work at a time; a finished result sits in an output register
// and the next input beat is taken in the cycle that result is consumed.
// ----------------------------------------------------------------------------
`include "tick_sleep_queue_core_assert.svh"

module tick_sleep_queue_core
    import tsq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [ThreadW-1:0] i_thread_id,
    input  logic [DelayW-1:0]  i_delay,
    input  logic               i_cpu_idle,
    input  logic               i_future_pending,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_woke_valid,
    output logic [ThreadW-1:0] o_woke_thread,
    output logic               o_yield_request,
    output logic               o_timer_off,
    output logic               o_queue_full
);

    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

    t_state             r_state, n_state;
    logic               r_rr_mode;
    logic [TickW-1:0]   r_tick;
    logic [CntW-1:0]    r_count;
    logic               r_cpu_idle;
    logic               r_future;

    logic               r_out_valid;
    logic               r_woke_valid;
    logic [ThreadW-1:0] r_woke_thread;
    logic               r_yield;
    logic               r_timer_off;
    logic               r_queue_full;

    logic               out_free;
    logic               in_acc;
    logic               scan_go;
    logic               sleep_acc;
    logic               tick_acc;
    logic               full;
    logic [TickW:0]     wake_sum;
    t_entry             new_entry;
    t_chain             chain [QUEUE_DEPTH+1];
    t_entry             ents  [QUEUE_DEPTH];
    logic               woke;
    logic [CntW-1:0]    count_after;
    logic               quiet;

    assign o_cfg_ready = 1'b1;

    assign out_free  = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;
    assign sleep_acc = in_acc && (i_action == ActSleep);
    assign tick_acc  = in_acc && (i_action == ActTick);
    assign full      = (r_count == CntW'(QUEUE_DEPTH));

    assign wake_sum            = {1'b0, r_tick} + {{(TickW + 1 - DelayW){1'b0}}, i_delay};
    assign new_entry.wake      = wake_sum[TickW] ? {TickW{1'b1}} : wake_sum[TickW-1:0];
    assign new_entry.thread    = i_thread_id;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (tick_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        scan_go    = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = out_free;
            ST_SCAN: scan_go    = out_free;
            default: ;
        endcase
    end

    assign chain[0] = '{hit: 1'b0, thread: '0};

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry nxt;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign nxt = ents[g];
        end else begin : g_mid
            assign nxt = ents[g+1];
        end
        tsq_cell u_cell (
            .i_clk      (i_clk),
            .i_live     (CntW'(g) < r_count),
            .i_load     (sleep_acc && !full && (r_count[IdxW-1:0] == IdxW'(g))),
            .i_new      (new_entry),
            .i_shift_en (scan_go),
            .i_next     (nxt),
            .i_tick     (r_tick),
            .i_chain    (chain[g]),
            .o_chain    (chain[g+1]),
            .o_entry    (ents[g])
        );
    end

    assign woke        = chain[QUEUE_DEPTH].hit;
    assign count_after = r_count - CntW'(woke);
    assign quiet       = r_cpu_idle && !woke && (count_after == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rr_mode   <= 1'b0;
            r_tick      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rr_mode <= i_cfg_data;
            end
            if (tick_acc && (r_tick != {TickW{1'b1}})) begin
                r_tick <= r_tick + TickW'(1);
            end
            if (sleep_acc && !full) begin
                r_count <= r_count + CntW'(1);
            end else if (scan_go) begin
                r_count <= count_after;
            end
            if (sleep_acc || scan_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold tick-side flags, load the result beat
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_cpu_idle <= i_cpu_idle;
            r_future   <= i_future_pending;
        end
        if (sleep_acc) begin
            r_woke_valid  <= 1'b0;
            r_woke_thread <= '0;
            r_yield       <= 1'b0;
            r_timer_off   <= 1'b0;
            r_queue_full  <= full;
        end else if (scan_go) begin
            r_woke_valid  <= woke;
            r_woke_thread <= chain[QUEUE_DEPTH].thread;
            r_yield       <= !quiet && r_rr_mode;
            r_timer_off   <= quiet && !r_future;
            r_queue_full  <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_woke_valid    = r_woke_valid;
    assign o_woke_thread   = r_woke_thread;
    assign o_yield_request = r_yield;
    assign o_timer_off     = r_timer_off;
    assign o_queue_full    = r_queue_full;

    `TSQ_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, sleep_acc && full, r_count == $past(r_count))
    `TSQ_ASSERT_IMP(a_woke_nonempty, i_clk, i_rst_n, scan_go && woke, r_count != '0)
    `TSQ_ASSERT_NEXT(a_tick_scan, i_clk, i_rst_n, tick_acc, r_state == ST_SCAN)
    `TSQ_ASSERT_IMP(a_off_exclusive, i_clk, i_rst_n, r_out_valid && r_timer_off, !r_woke_valid && !r_yield)

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tick_sleep_queue_core.
// ----------------------------------------------------------------------------
// Drives tick and sleep beats with random gaps and output stalls. Every
// accepted beat runs through a sleep-queue predictor kept in the bench. Each
// result beat is compared with the oldest predicted result. Directed tests
// cover the idle and round-robin tick decisions, wake order, a full queue and
// the longest delay; random phases in both scheduler modes run before it.
// ----------------------------------------------------------------------------
module tb;
    import tsq_pkg::*;

    localparam int unsigned QueueDepth = 16;
    localparam int unsigned CycleLimit = 100_000;

    typedef struct packed {
        logic               woke;
        logic [ThreadW-1:0] thread;
        logic               yield_req;
        logic               toff;
        logic               full;
    } t_wake_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               in_action = ActTick;
    logic [ThreadW-1:0] in_thread = '0;
    logic [DelayW-1:0]  in_delay = '0;
    logic               in_idle = 1'b0;
    logic               in_future = 1'b0;
    logic               out_valid;
    logic               out_rdy = 1'b0;
    logic               woke_valid;
    logic [ThreadW-1:0] woke_thread;
    logic               yield_request;
    logic               timer_off;
    logic               queue_full;

    logic               rr_mode = 1'b0;
    logic [TickW-1:0]   ticks = '0;
    logic [TickW-1:0]   wake_q[$];
    logic [ThreadW-1:0] sleeper_q[$];
    t_wake_result       due_results[$];

    bit                 gaps_on = 1'b1;
    int unsigned        rx_wait = 0;
    int unsigned        fail_count = 0;
    int unsigned        cycle_count = 0;

    tick_sleep_queue_core #(
        .QUEUE_DEPTH(QueueDepth)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_action         (in_action),
        .i_thread_id      (in_thread),
        .i_delay          (in_delay),
        .i_cpu_idle       (in_idle),
        .i_future_pending (in_future),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_rdy),
        .o_woke_valid     (woke_valid),
        .o_woke_thread    (woke_thread),
        .o_yield_request  (yield_request),
        .o_timer_off      (timer_off),
        .o_queue_full     (queue_full)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int unsigned want_v, int unsigned got_v);
        fail_count++;
        $display("%0t: %s expected %0h actual %0h", $time, what, want_v, got_v);
    endtask

    task automatic predict_beat(logic act, logic [ThreadW-1:0] tid, logic [DelayW-1:0] dly,
                                logic idle, logic fut);
        t_wake_result     r;
        logic [TickW:0]   sum;
        logic [TickW-1:0] wt;
        int               hit;
        r = '0;
        hit = -1;
        if (act == ActSleep) begin
            if (sleeper_q.size() >= QueueDepth) begin
                r.full = 1'b1;
            end else begin
                sum = {1'b0, ticks} + dly;
                wt = sum[TickW] ? {TickW{1'b1}} : sum[TickW-1:0];
                wake_q = {wake_q, wt};
                sleeper_q = {sleeper_q, tid};
            end
        end else begin
            if (ticks != '1)
                ticks++;
            for (int i = 0; i < wake_q.size() && hit < 0; i++)
                if (ticks >= wake_q[i])
                    hit = i;
            if (hit >= 0) begin
                r.woke   = 1'b1;
                r.thread = sleeper_q[hit];
                wake_q.delete(hit);
                sleeper_q.delete(hit);
            end
            if (idle && !r.woke && wake_q.size() == 0)
                r.toff = !fut;
            else
                r.yield_req = rr_mode;
        end
        due_results = {due_results, r};
    endtask

    // Leaves valid high after the beat; the next send or drain_queue moves it.
    task automatic send_beat(logic act, logic [ThreadW-1:0] tid, logic [DelayW-1:0] dly,
                             logic idle, logic fut);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_thread <= tid;
        in_delay  <= dly;
        in_idle   <= idle;
        in_future <= fut;
        do @(posedge i_clk); while (!in_ready);
        predict_beat(act, tid, dly, idle, fut);
    endtask

    task automatic drain_queue();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_mode(logic rr);
        drain_queue();
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rr;
        do @(posedge i_clk); while (!cfg_ready);
        rr_mode = rr;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_wake_result want;
        if (i_rst_n && out_valid && out_rdy) begin
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result, woke_thread", 0, woke_thread);
            end else begin
                want = due_results.pop_front();
                if (woke_valid !== want.woke)
                    report_mismatch("woke_valid", want.woke, woke_valid);
                if (woke_thread !== want.thread)
                    report_mismatch("woke_thread", want.thread, woke_thread);
                if (yield_request !== want.yield_req)
                    report_mismatch("yield_request", want.yield_req, yield_request);
                if (timer_off !== want.toff)
                    report_mismatch("timer_off", want.toff, timer_off);
                if (queue_full !== want.full)
                    report_mismatch("queue_full", want.full, queue_full);
            end
            rx_wait = gaps_on ? $urandom_range(0, 8) : 0;
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
    end

    always @(negedge i_clk) begin
        out_rdy <= (rx_wait == 0);
    end

    task automatic tick_all_modes();
        send_beat(ActTick, 8'hFF, 16'hFFFF, 1'b1, 1'b0);
        send_beat(ActTick, 8'h00, 16'h0000, 1'b1, 1'b1);
        send_beat(ActTick, 8'hA5, 16'h5A5A, 1'b0, 1'b0);
        send_beat(ActTick, 8'h5A, 16'hA5A5, 1'b0, 1'b1);
    endtask

    task automatic test_idle_ticks();
        tick_all_modes();
    endtask

    task automatic test_round_robin();
        write_mode(1'b1);
        tick_all_modes();
    endtask

    task automatic test_wake_order();
        send_beat(ActSleep, 8'h00, 16'd0, 1'b1, 1'b1);
        send_beat(ActSleep, 8'hFF, 16'd3, 1'b0, 1'b0);
        send_beat(ActSleep, 8'h5A, 16'd1, 1'b1, 1'b0);
        send_beat(ActSleep, 8'h3C, 16'd1, 1'b0, 1'b1);
        repeat (5) send_beat(ActTick, 8'h00, 16'h0000, 1'b1, 1'b0);
    endtask

    task automatic test_queue_full();
        write_mode(1'b0);
        repeat (QueueDepth + 2)
            send_beat(ActSleep, ThreadW'($urandom_range(0, 255)),
                      DelayW'($urandom_range(1, 3)), 1'b0, 1'b0);
        repeat (QueueDepth + 3) send_beat(ActTick, 8'h00, 16'h0000, 1'b1, 1'b0);
    endtask

    task automatic test_random_traffic();
        int unsigned sleep_pct;
        logic [DelayW-1:0] dly;
        for (int phase = 0; phase < 4; phase++) begin
            write_mode(phase[0]);
            sleep_pct = 35 + 10 * phase;
            repeat (135) begin
                if ($urandom_range(0, 39) == 0)
                    gaps_on = !gaps_on;
                dly = ($urandom_range(0, 9) == 0) ? DelayW'($urandom_range(0, 63))
                                                  : DelayW'($urandom_range(0, 20));
                send_beat(($urandom_range(0, 99) < sleep_pct) ? ActSleep : ActTick,
                          ThreadW'($urandom_range(0, 255)), dly,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_longest_delay();
        write_mode(1'b0);
        gaps_on = 1'b0;
        send_beat(ActSleep, ThreadW'($urandom_range(0, 255)), 16'hFFFF, 1'b0, 1'b0);
        repeat (8)
            send_beat(ActTick, ThreadW'($urandom_range(0, 255)),
                      DelayW'($urandom_range(0, 16'hFFFF)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        gaps_on = 1'b1;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_round_robin();
        test_wake_order();
        test_queue_full();
        test_random_traffic();
        test_longest_delay();

        drain_queue();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
